// ===== rtl/core/consensus_kmodes_clustering_core_assert.svh =====
// Assertion macros used by the core RTL file consensus_kmodes_clustering_core.sv.
`ifndef CONSENSUS_KMODES_CLUSTERING_CORE_ASSERT_SVH
`define CONSENSUS_KMODES_CLUSTERING_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define CKM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define CKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ckm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ckm_pkg;

  localparam int unsigned MAX_ELEMENTS  = 1024;
  localparam int unsigned MAX_LABELINGS = 16;
  localparam int unsigned MAX_GROUPS    = 16;
  localparam int unsigned LABEL_VALUES  = 64;

  localparam int unsigned EL_W   = $clog2(MAX_ELEMENTS);
  localparam int unsigned LB_W   = $clog2(MAX_LABELINGS);
  localparam int unsigned GR_W   = $clog2(MAX_GROUPS);
  localparam int unsigned LAB_W  = $clog2(LABEL_VALUES);
  localparam int unsigned NL_W   = $clog2(MAX_LABELINGS + 1);
  localparam int unsigned NG_W   = $clog2(MAX_GROUPS + 1);
  localparam int unsigned NE_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CNT_W  = NE_W;
  localparam int unsigned DIST_W = NL_W;
  localparam int unsigned SUM_W  = $clog2(MAX_ELEMENTS * MAX_LABELINGS + 1);
  localparam int unsigned CFG_W  = NE_W;

  localparam int unsigned PT_AW  = EL_W + LB_W;
  localparam int unsigned CT_AW  = GR_W + LB_W;
  localparam int unsigned VT_AW  = GR_W + LB_W + LAB_W;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SEED = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NUM_LABELINGS = 2'd0,
    REG_NUM_GROUPS    = 2'd1,
    REG_NUM_ELEMENTS  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_e;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/consensus_kmodes_clustering_core.sv =====
// Load writes a label into the point memory. Seed copies a point into a center. Read
// returns the assignment of an element in an output register. Run: each assignment pass
// goes through the point and center memories, each center update does a vote
// read-modify-write and a mode scan over the vote memory; one item is worked at a time.
// Reset is asynchronous and active low; after it the vote memory is cleared in a pass
// during which no transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "consensus_kmodes_clustering_core_assert.svh"
module consensus_kmodes_clustering_core
  import ckm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [EL_W-1:0]    element_index_i,
  input  wire logic [LB_W-1:0]    labeling_index_i,
  input  wire logic [GR_W-1:0]    group_index_i,
  input  wire logic [LAB_W-1:0]   label_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    result_kind_o,
  output logic [GR_W-1:0]         group_o,
  output logic [SUM_W-1:0]        distance_sum_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SEED, S_RD, S_RA, S_RA_W, S_VP, S_VC, S_VW, S_MS, S_MS_W, S_DONE
  } state_e;

  typedef enum logic [1:0] {P_SEED, P_RA, P_MS} pipe_e;

  state_e state_q, state_d;
  pipe_e  p_kind_q, p_kind_d;
  logic   p_valid_q, p_valid_d;

  logic [NL_W-1:0]  nl_cfg_q, nl_cfg_d, nl;
  logic [NG_W-1:0]  ng_cfg_q, ng_cfg_d, ng;
  logic [NE_W-1:0]  ne_cfg_q, ne_cfg_d, ne;
  logic [LB_W-1:0]  nl_m1;
  logic [GR_W-1:0]  ng_m1;
  logic [EL_W-1:0]  ne_m1;

  logic [EL_W-1:0]  i_q, i_d, el_q, el_d, p_i_q, p_i_d;
  logic [GR_W-1:0]  g_q, g_d, gr_q, gr_d, p_g_q, p_g_d, best_q, best_d;
  logic [LB_W-1:0]  j_q, j_d, p_j_q, p_j_d;
  logic [LAB_W-1:0] k_q, k_d, p_k_q, p_k_d, mk_q, mk_d;
  logic [VT_AW-1:0] clr_q, clr_d;
  logic [DIST_W-1:0] d_q, d_d, bd_q, bd_d;
  logic [CNT_W-1:0] mb_q, mb_d;
  logic [SUM_W-1:0] sum_q, sum_d, prev_q, prev_d;
  logic             first_q, first_d;

  logic             out_valid_q, out_valid_d, out_kind_q, out_kind_d;
  logic [GR_W-1:0]  out_group_q, out_group_d;
  logic [SUM_W-1:0] out_sum_q, out_sum_d;
  logic             out_free;

  logic             pt_we, ct_we, as_we, vt_we;
  logic [PT_AW-1:0] pt_waddr, pt_raddr;
  logic [CT_AW-1:0] ct_waddr, ct_raddr;
  logic [EL_W-1:0]  as_waddr, as_raddr;
  logic [VT_AW-1:0] vt_waddr, vt_raddr;
  logic [LAB_W-1:0] pt_wdata, pt_rdata, ct_wdata, ct_rdata;
  logic [GR_W-1:0]  as_wdata, as_rdata;
  logic [CNT_W-1:0] vt_wdata, vt_rdata;

  logic [DIST_W-1:0] dn, bdn;
  logic [GR_W-1:0]   bestn;
  logic [CNT_W-1:0]  mbase, mbn;
  logic [LAB_W-1:0]  mkn;

  ckm_ram #(.Width(LAB_W), .Depth(MAX_ELEMENTS * MAX_LABELINGS)) u_point_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );

  ckm_ram #(.Width(LAB_W), .Depth(MAX_GROUPS * MAX_LABELINGS)) u_center_ram (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .raddr_i(ct_raddr), .rdata_o(ct_rdata)
  );

  ckm_ram #(.Width(GR_W), .Depth(MAX_ELEMENTS)) u_assign_ram (
    .clk_i, .we_i(as_we), .waddr_i(as_waddr), .wdata_i(as_wdata),
    .raddr_i(as_raddr), .rdata_o(as_rdata)
  );

  ckm_ram #(.Width(CNT_W), .Depth(MAX_GROUPS * MAX_LABELINGS * LABEL_VALUES)) u_vote_ram (
    .clk_i, .we_i(vt_we), .waddr_i(vt_waddr), .wdata_i(vt_wdata),
    .raddr_i(vt_raddr), .rdata_o(vt_rdata)
  );

  always_comb begin
    nl = (nl_cfg_q == '0) ? NL_W'(1) :
         (nl_cfg_q > NL_W'(MAX_LABELINGS)) ? NL_W'(MAX_LABELINGS) : nl_cfg_q;
    ng = (ng_cfg_q == '0) ? NG_W'(1) :
         (ng_cfg_q > NG_W'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : ng_cfg_q;
    ne = (ne_cfg_q == '0) ? NE_W'(1) :
         (ne_cfg_q > NE_W'(MAX_ELEMENTS)) ? NE_W'(MAX_ELEMENTS) : ne_cfg_q;
    nl_m1 = LB_W'(nl - NL_W'(1));
    ng_m1 = GR_W'(ng - NG_W'(1));
    ne_m1 = EL_W'(ne - NE_W'(1));
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    p_kind_d = p_kind_q;
    p_valid_d = 1'b0;
    nl_cfg_d = nl_cfg_q;
    ng_cfg_d = ng_cfg_q;
    ne_cfg_d = ne_cfg_q;
    i_d = i_q; el_d = el_q; p_i_d = p_i_q;
    g_d = g_q; gr_d = gr_q; p_g_d = p_g_q; best_d = best_q;
    j_d = j_q; p_j_d = p_j_q;
    k_d = k_q; p_k_d = p_k_q; mk_d = mk_q;
    clr_d = clr_q;
    d_d = d_q; bd_d = bd_q; mb_d = mb_q;
    sum_d = sum_q; prev_d = prev_q; first_d = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d = out_kind_q;
    out_group_d = out_group_q;
    out_sum_d = out_sum_q;

    pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_raddr = '0;
    ct_we = 1'b0; ct_waddr = '0; ct_wdata = '0; ct_raddr = '0;
    as_we = 1'b0; as_waddr = '0; as_wdata = '0; as_raddr = '0;
    vt_we = 1'b0; vt_waddr = '0; vt_wdata = '0; vt_raddr = '0;
    dn = '0; bdn = '0; bestn = '0; mbase = '0; mbn = '0; mkn = '0;

    if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_NUM_LABELINGS: nl_cfg_d = NL_W'(cfg_data_i);
        REG_NUM_GROUPS:    ng_cfg_d = NG_W'(cfg_data_i);
        REG_NUM_ELEMENTS:  ne_cfg_d = cfg_data_i;
        default: ;
      endcase
    end

    if (p_valid_q) begin
      case (p_kind_q)
        P_SEED: begin
          ct_we = 1'b1;
          ct_waddr = {gr_q, p_j_q};
          ct_wdata = pt_rdata;
        end
        P_RA: begin
          dn = ((p_j_q == '0) ? '0 : d_q) + DIST_W'(ct_rdata != pt_rdata);
          d_d = dn;
          if (p_j_q == nl_m1) begin
            if (p_g_q == '0 || dn < bd_q) begin
              bdn = dn;
              bestn = p_g_q;
            end else begin
              bdn = bd_q;
              bestn = best_q;
            end
            bd_d = bdn;
            best_d = bestn;
            if (p_g_q == ng_m1) begin
              as_we = 1'b1;
              as_waddr = p_i_q;
              as_wdata = bestn;
              sum_d = sum_q + SUM_W'(bdn);
            end
          end
        end
        P_MS: begin
          vt_we = 1'b1;
          vt_waddr = {p_g_q, p_j_q, p_k_q};
          vt_wdata = '0;
          mbase = (p_k_q == '0) ? '0 : mb_q;
          if (vt_rdata > mbase) begin
            mbn = vt_rdata;
            mkn = p_k_q;
          end else begin
            mbn = mbase;
            mkn = mk_q;
          end
          mb_d = mbn;
          mk_d = mkn;
          if (p_k_q == LAB_W'(LABEL_VALUES - 1) && mbn != '0) begin
            ct_we = 1'b1;
            ct_waddr = {p_g_q, p_j_q};
            ct_wdata = mkn;
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      S_CLR: begin
        vt_we = 1'b1;
        vt_waddr = clr_q;
        vt_wdata = '0;
        clr_d = clr_q + VT_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        as_raddr = element_index_i;
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_LOAD: begin
              pt_we = 1'b1;
              pt_waddr = {element_index_i, labeling_index_i};
              pt_wdata = label_i;
            end
            CMD_SEED: begin
              el_d = element_index_i;
              gr_d = group_index_i;
              j_d = '0;
              state_d = S_SEED;
            end
            CMD_RUN: begin
              i_d = '0; g_d = '0; j_d = '0;
              sum_d = '0;
              first_d = 1'b1;
              state_d = S_RA;
            end
            CMD_READ: begin
              el_d = element_index_i;
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_SEED: begin
        pt_raddr = {el_q, j_q};
        p_valid_d = 1'b1;
        p_kind_d = P_SEED;
        p_j_d = j_q;
        j_d = j_q + LB_W'(1);
        if (j_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        as_raddr = el_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d = KIND_READ;
          out_group_d = as_rdata;
          out_sum_d = '0;
          state_d = S_IDLE;
        end
      end
      S_RA: begin
        pt_raddr = {i_q, j_q};
        ct_raddr = {g_q, j_q};
        p_valid_d = 1'b1;
        p_kind_d = P_RA;
        p_i_d = i_q; p_g_d = g_q; p_j_d = j_q;
        j_d = j_q + LB_W'(1);
        if (j_q == nl_m1) begin
          j_d = '0;
          g_d = g_q + GR_W'(1);
          if (g_q == ng_m1) begin
            g_d = '0;
            i_d = i_q + EL_W'(1);
            if (i_q == ne_m1) begin
              state_d = S_RA_W;
            end
          end
        end
      end
      S_RA_W: begin
        if (first_q || sum_d < prev_q) begin
          prev_d = sum_d;
          first_d = 1'b0;
          i_d = '0; j_d = '0;
          state_d = S_VP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_VP: begin
        pt_raddr = {i_q, j_q};
        as_raddr = i_q;
        state_d = S_VC;
      end
      S_VC: begin
        pt_raddr = {i_q, j_q};
        as_raddr = i_q;
        vt_raddr = {as_rdata, j_q, pt_rdata};
        state_d = S_VW;
      end
      S_VW: begin
        pt_raddr = {i_q, j_q};
        as_raddr = i_q;
        vt_we = 1'b1;
        vt_waddr = {as_rdata, j_q, pt_rdata};
        vt_wdata = vt_rdata + CNT_W'(1);
        state_d = S_VP;
        j_d = j_q + LB_W'(1);
        if (j_q == nl_m1) begin
          j_d = '0;
          i_d = i_q + EL_W'(1);
          if (i_q == ne_m1) begin
            g_d = '0; k_d = '0;
            state_d = S_MS;
          end
        end
      end
      S_MS: begin
        vt_raddr = {g_q, j_q, k_q};
        p_valid_d = 1'b1;
        p_kind_d = P_MS;
        p_g_d = g_q; p_j_d = j_q; p_k_d = k_q;
        k_d = k_q + LAB_W'(1);
        if (k_q == LAB_W'(LABEL_VALUES - 1)) begin
          k_d = '0;
          j_d = j_q + LB_W'(1);
          if (j_q == nl_m1) begin
            j_d = '0;
            g_d = g_q + GR_W'(1);
            if (g_q == ng_m1) begin
              g_d = '0;
              state_d = S_MS_W;
            end
          end
        end
      end
      S_MS_W: begin
        i_d = '0; g_d = '0; j_d = '0;
        sum_d = '0;
        state_d = S_RA;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d = KIND_RUN;
          out_group_d = '0;
          out_sum_d = sum_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      p_valid_q <= 1'b0;
      p_kind_q <= P_SEED;
      nl_cfg_q <= NL_W'(1);
      ng_cfg_q <= NG_W'(2);
      ne_cfg_q <= NE_W'(1);
      clr_q <= '0;
      i_q <= '0; g_q <= '0; j_q <= '0; k_q <= '0;
      sum_q <= '0;
      prev_q <= '0;
      first_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_valid_q <= p_valid_d;
      p_kind_q <= p_kind_d;
      nl_cfg_q <= nl_cfg_d;
      ng_cfg_q <= ng_cfg_d;
      ne_cfg_q <= ne_cfg_d;
      clr_q <= clr_d;
      i_q <= i_d; g_q <= g_d; j_q <= j_d; k_q <= k_d;
      sum_q <= sum_d;
      prev_q <= prev_d;
      first_q <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q <= el_d; gr_q <= gr_d;
    p_i_q <= p_i_d; p_g_q <= p_g_d; p_j_q <= p_j_d; p_k_q <= p_k_d;
    best_q <= best_d; mk_q <= mk_d;
    d_q <= d_d; bd_q <= bd_d; mb_q <= mb_d;
    out_kind_q <= out_kind_d;
    out_group_q <= out_group_d;
    out_sum_q <= out_sum_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign group_o = out_group_q;
  assign distance_sum_o = out_sum_q;

  `CKM_ASSERT_IMPLY(a_pipe_state, p_valid_q,
    state_q == S_IDLE || state_q == S_SEED || state_q == S_RA || state_q == S_RA_W ||
    state_q == S_MS || state_q == S_MS_W, "pipeline commit outside a memory pass")
  `CKM_ASSERT_IMPLY(a_done_after_update, state_q == S_DONE, !first_q,
    "run finished without a center update")
  `CKM_ASSERT_IMPLY(a_ra_range, state_q == S_RA,
    g_q <= ng_m1 && j_q <= nl_m1, "assignment counters out of range")
  `CKM_ASSERT_NEXT(a_clr_exit, state_q == S_CLR,
    state_q == S_CLR || state_q == S_IDLE, "clearing pass left early")

endmodule
`default_nettype wire

// ===== rtl/core/ckm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ckm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(Depth)-1:0]         waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic [$clog2(Depth)-1:0]         raddr_i,
  output logic      [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
